### sv/aimc_pkg.sv
// ============================================================================
// aimc_pkg
// Shared types and constants of the auto-increment memory card core.
// ============================================================================
package aimc_pkg;

    localparam int CMD_W      = 2;
    localparam int OFFSET_W   = 11;
    localparam int BYTE_W     = 8;
    localparam int PTR_W      = 24;
    localparam int ROM_ADDR_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int SLOT_W     = 3;
    localparam int REG_SEL_W  = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_REG_READ  = 2'd0,
        CMD_REG_WRITE = 2'd1,
        CMD_SLOT_ROM  = 2'd2,
        CMD_EXP_ROM   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BANK_HIGH_OR  = 2'd0,
        CFG_ADDRESS_MASK  = 2'd1,
        CFG_ROM_BANK_VAR  = 2'd2,
        CFG_SLOT_NUMBER   = 2'd3
    } t_cfg_idx;

    // register file map
    localparam logic [REG_SEL_W-1:0] REG_ADDR_LO   = 4'd0;
    localparam logic [REG_SEL_W-1:0] REG_ADDR_MID  = 4'd1;
    localparam logic [REG_SEL_W-1:0] REG_ADDR_HI   = 4'd2;
    localparam logic [REG_SEL_W-1:0] REG_DATA_PORT = 4'd3;
    localparam logic [REG_SEL_W-1:0] REG_ROM_BANK  = 4'd15;

    // reset values of the configuration registers
    localparam logic [BYTE_W-1:0] BANK_HIGH_OR_RST = 8'hF0;
    localparam logic [PTR_W-1:0]  ADDR_MASK_RST    = 24'h0F_FFFF;
    localparam logic [SLOT_W-1:0] SLOT_NUMBER_RST  = 3'd1;

    // ram contents after reset
    localparam logic [BYTE_W-1:0] RAM_FILL = 8'hFF;

    // rom window bases
    localparam logic [ROM_ADDR_W-1:0] ROM_SLOT_BANK_OFS = 13'h1000;
    localparam logic [ROM_ADDR_W-1:0] ROM_EXP_BASE      = 13'h0800;
    localparam logic [ROM_ADDR_W-1:0] ROM_EXP_BANK_BASE = 13'h1800;

endpackage

### sv/auto_increment_memory_card_core.sv
// ============================================================================
// auto_increment_memory_card_core
// Sixteen byte registers in front of an auto-increment address/data port
// onto a byte RAM, plus slot and expansion ROM address generation.
// ============================================================================
// a transaction taken at one edge while busy is low shows its result with o_valid high
//   during the next cycle; one transaction per cycle, except while busy is high
// the ram has a single port, used only by data port reads and writes
// reset: synchronous, active low; afterward the ram is swept to 0xFF, one byte
//   per cycle over all 2**RAM_ADDR_BITS bytes (1048576 at the default), busy high
//   meanwhile; configuration writes are taken during the sweep
// the receiver cannot stall, so results are never held back
module auto_increment_memory_card_core #(
    parameter int RAM_ADDR_BITS = 20,
    parameter int REG_COUNT     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // transaction input
    input  logic                               start,
    output logic                               busy,
    input  logic [aimc_pkg::CMD_W-1:0]         i_command,
    input  logic [aimc_pkg::OFFSET_W-1:0]      i_offset,
    input  logic [aimc_pkg::BYTE_W-1:0]        i_write_data,
    // result
    output logic                               o_valid,
    output logic [aimc_pkg::BYTE_W-1:0]        o_read_data,
    output logic [aimc_pkg::ROM_ADDR_W-1:0]    o_rom_address,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [aimc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [aimc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import aimc_pkg::*;

    localparam int REG_IDX_W = $clog2(REG_COUNT);

    // configuration
    logic [BYTE_W-1:0]     r_bank_high_or;
    logic [PTR_W-1:0]      r_address_mask;
    logic                  r_rom_bank_var;
    logic [SLOT_W-1:0]     r_slot_number;

    // card state
    logic [BYTE_W-1:0]     r_regs [REG_COUNT];
    logic [BYTE_W-1:0]     n_regs [REG_COUNT];
    logic [PTR_W-1:0]      r_latch, n_latch;
    logic [PTR_W-1:0]      r_ptr, n_ptr;

    // result register
    logic                  r_valid;
    logic                  r_rd_from_ram, n_rd_from_ram;
    logic [BYTE_W-1:0]     r_rd, n_rd;
    logic [ROM_ADDR_W-1:0] r_ra, n_ra;

    // ram side
    logic                     ram_we;
    logic                     ram_re;
    logic [RAM_ADDR_BITS-1:0] ram_addr;
    logic [BYTE_W-1:0]        ram_rdata;
    logic                     ram_clearing;

    logic                  accept;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  banked;
    logic [PTR_W-1:0]      ptr_inc;
    t_cmd                  cmd;

    assign busy    = ram_clearing;
    assign accept  = start && !busy;
    assign cmd     = t_cmd'(i_command);
    assign reg_idx = i_offset[REG_IDX_W-1:0];
    // upper rom bank selected by register 15 bit 0 on the banking variant
    assign banked  = r_rom_bank_var && r_regs[REG_IDX_W'(REG_ROM_BANK)][0];
    assign ptr_inc = r_ptr + 1'b1;
    // mask first, then wrap onto the physical store size
    assign ram_addr = RAM_ADDR_BITS'(r_ptr & r_address_mask);

    always_comb begin
        n_regs        = r_regs;
        n_latch       = r_latch;
        n_ptr         = r_ptr;
        n_rd          = '0;
        n_ra          = '0;
        n_rd_from_ram = 1'b0;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        if (accept) begin
            unique case (cmd)
                CMD_REG_READ: begin
                    if (reg_idx == REG_IDX_W'(REG_DATA_PORT)) begin
                        // data port read: ram byte, then step the pointer
                        ram_re        = 1'b1;
                        n_rd_from_ram = 1'b1;
                        n_ptr         = ptr_inc;
                    end else begin
                        n_rd = r_regs[reg_idx];
                    end
                end
                CMD_REG_WRITE: begin
                    if (reg_idx <= REG_IDX_W'(REG_ADDR_HI)) begin
                        // address byte write loads the live pointer directly
                        for (int b = 0; b < 3; b++) begin
                            if (reg_idx == REG_IDX_W'(b)) begin
                                n_latch[8*b +: 8] = i_write_data;
                            end
                        end
                        n_ptr = n_latch;
                    end else if (reg_idx == REG_IDX_W'(REG_DATA_PORT)) begin
                        ram_we = 1'b1;
                        n_ptr  = ptr_inc;
                    end else begin
                        n_regs[reg_idx] = i_write_data;
                    end
                end
                CMD_SLOT_ROM: begin
                    // 256-byte image per slot
                    n_ra = {2'b00, r_slot_number, i_offset[7:0]};
                    if (banked) begin
                        n_ra = n_ra + ROM_SLOT_BANK_OFS;
                    end
                end
                CMD_EXP_ROM: begin
                    n_ra = ROM_ADDR_W'(i_offset) +
                           (banked ? ROM_EXP_BANK_BASE : ROM_EXP_BASE);
                end
                default: begin
                end
            endcase
            // readback bytes track the live pointer whenever it is reloaded or steps
            if (n_ptr != r_ptr || (cmd == CMD_REG_WRITE &&
                                   reg_idx <= REG_IDX_W'(REG_ADDR_HI)) ||
                ram_we || ram_re) begin
                n_regs[REG_IDX_W'(REG_ADDR_LO)]  = n_ptr[7:0];
                n_regs[REG_IDX_W'(REG_ADDR_MID)] = n_ptr[15:8];
                n_regs[REG_IDX_W'(REG_ADDR_HI)]  = n_ptr[23:16] | r_bank_high_or;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_high_or <= BANK_HIGH_OR_RST;
            r_address_mask <= ADDR_MASK_RST;
            r_rom_bank_var <= 1'b0;
            r_slot_number  <= SLOT_NUMBER_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_BANK_HIGH_OR: r_bank_high_or <= i_cfg_wdata[BYTE_W-1:0];
                CFG_ADDRESS_MASK: r_address_mask <= i_cfg_wdata[PTR_W-1:0];
                CFG_ROM_BANK_VAR: r_rom_bank_var <= i_cfg_wdata[0];
                CFG_SLOT_NUMBER:  r_slot_number  <= i_cfg_wdata[SLOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // card state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= '0;
            end
            r_latch       <= '0;
            r_ptr         <= '0;
            r_valid       <= 1'b0;
            r_rd_from_ram <= 1'b0;
        end else begin
            r_regs        <= n_regs;
            r_latch       <= n_latch;
            r_ptr         <= n_ptr;
            r_valid       <= accept;
            r_rd_from_ram <= n_rd_from_ram;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= n_rd;
        r_ra <= n_ra;
    end

    aimc_ram #(
        .ADDR_BITS (RAM_ADDR_BITS)
    ) u_ram (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (ram_we),
        .i_re       (ram_re),
        .i_addr     (ram_addr),
        .i_wdata    (i_write_data),
        .o_rdata    (ram_rdata),
        .o_clearing (ram_clearing)
    );

    // data port reads take the registered ram byte
    assign o_valid       = r_valid;
    assign o_read_data   = r_rd_from_ram ? ram_rdata : r_rd;
    assign o_rom_address = r_ra;

endmodule

### sv/aimc_ram.sv
// ============================================================================
// aimc_ram
// Single-port byte RAM with registered read and a fill pass after reset.
// ============================================================================
module aimc_ram #(
    parameter int ADDR_BITS = 20
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic                           i_re,
    input  logic [ADDR_BITS-1:0]           i_addr,
    input  logic [aimc_pkg::BYTE_W-1:0]    i_wdata,
    output logic [aimc_pkg::BYTE_W-1:0]    o_rdata,
    output logic                           o_clearing
);
    import aimc_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [BYTE_W-1:0]    r_mem [DEPTH];
    logic [BYTE_W-1:0]    r_q;
    logic [ADDR_BITS-1:0] r_clr_addr;
    logic                 r_clearing;

    // fill sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == {ADDR_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= RAM_FILL;
        end else if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata    = r_q;
    assign o_clearing = r_clearing;

endmodule

### sv/aimc_checker.sv
// ============================================================================
// aimc_checker
// Port-level checks of the auto-increment memory card core.
// ============================================================================
module aimc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [aimc_pkg::CMD_W-1:0]         i_command,
    input logic                               o_valid,
    input logic [aimc_pkg::BYTE_W-1:0]        o_read_data,
    input logic [aimc_pkg::ROM_ADDR_W-1:0]    o_rom_address
);
    import aimc_pkg::*;

    // ram fill pass follows every reset
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("transaction gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without transaction");

    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command == CMD_REG_WRITE) |=>
            (o_read_data == '0 && o_rom_address == '0))
        else $error("register write result not zero");

    a_rom_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command == CMD_SLOT_ROM || i_command == CMD_EXP_ROM))
            |=> o_read_data == '0)
        else $error("rom read returned data");

endmodule

bind auto_increment_memory_card_core aimc_checker u_aimc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_command     (i_command),
    .o_valid       (o_valid),
    .o_read_data   (o_read_data),
    .o_rom_address (o_rom_address)
);
